/* sv/uhct_pkg.sv */
// Shared constants, field widths, status codes and the remainder-unit request type
// for the universal hash table with chaining. No dependencies.
package uhct_pkg;

    // table geometry
    localparam int BUCKETS     = 256;
    localparam int CHAIN_DEPTH = 8;
    localparam int KEY_BITS    = 16;
    localparam int SLOTS       = BUCKETS * CHAIN_DEPTH;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LEN_W  = $clog2(CHAIN_DEPTH + 1);

    // fixed port and register widths
    localparam int KEY_W      = 16;
    localparam int COEFF_W    = 17;
    localparam int MOD_W      = 17;
    localparam int MCNT_W     = 9;
    localparam int CFG_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int BUCKET_W   = 8;
    localparam int ST_W       = 2;
    localparam int TOTAL_W    = 12;
    localparam int LONGEST_W  = 4;
    localparam int NONEMPTY_W = 9;

    // a*k + b before reduction
    localparam int VAL_W  = COEFF_W + KEY_BITS + 1;
    localparam int STEP_W = $clog2(VAL_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKETS = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic               start;
        logic [VAL_W-1:0]   dividend;
        logic [MOD_W-1:0]   divisor;
    } t_rem_req;

endpackage

/* sv/uhct_rem_unit.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on uhct_pkg (widths, t_rem_req).
module uhct_rem_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  uhct_pkg::t_rem_req      i_req,
    output logic                    o_done,
    output logic [uhct_pkg::MOD_W-1:0] o_rem
);
    import uhct_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [VAL_W-1:0]    r_dvd;
    logic [MOD_W-1:0]    r_rem;
    logic [MOD_W-1:0]    r_dsr;

    logic [MOD_W:0]      trial;
    logic [MOD_W:0]      diff;
    logic [MOD_W-1:0]    n_rem;

    // partial remainder stays below the divisor, so the shifted trial fits MOD_W+1 bits
    always_comb begin
        trial = {r_rem, r_dvd[VAL_W-1]};
        diff  = trial - {1'b0, r_dsr};
        n_rem = (trial >= {1'b0, r_dsr}) ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(VAL_W - 1);
                r_dvd  <= i_req.dividend;
                r_rem  <= '0;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= r_dvd << 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* sv/universal_hash_chained_table_unit.sv */
// Universal hash table with bounded chaining: top level, sequencer, key and length stores.
// Depends on uhct_pkg and uhct_rem_unit.
// Time from start to result depends on the chain length L (up to 8) and is set by the
//   bit-serial remainder unit, which runs two 34-step reductions (one when the prime
//   register is zero), and by one key-store read per chain entry scanned.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset: synchronous, active low; clears sequencer, statistics and per-bucket valid bits.
//   The key store is not cleared. The result strobe cannot be stalled by the receiver.
module universal_hash_chained_table_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item input
    input  logic                               start,
    output logic                               busy,
    input  logic [uhct_pkg::KEY_W-1:0]         i_key,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [uhct_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [uhct_pkg::CFG_W-1:0]         i_cfg_data,
    // result
    output logic                               o_result_valid,
    output logic [uhct_pkg::BUCKET_W-1:0]      o_bucket,
    output logic [uhct_pkg::ST_W-1:0]          o_status,
    output logic [uhct_pkg::TOTAL_W-1:0]       o_stored_total,
    output logic [uhct_pkg::LONGEST_W-1:0]     o_longest_chain,
    output logic [uhct_pkg::NONEMPTY_W-1:0]    o_nonempty_total
);
    import uhct_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,      // a*k + b
        S_RED1,     // launch mod p
        S_WAIT1,
        S_RED2,     // launch mod m
        S_WAIT2,
        S_LEN_RD,   // chain length read in flight
        S_LEN_CHK,
        S_SCAN_RD,  // chain entry read in flight
        S_SCAN_CMP,
        S_DECIDE    // insert / duplicate / full, drive result
    } t_state;

    // ---------------- configuration registers ----------------
    logic [COEFF_W-1:0]  r_coeff_a;
    logic [COEFF_W-1:0]  r_coeff_b;
    logic [MOD_W-1:0]    r_prime;
    logic [MCNT_W-1:0]   r_bucket_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_a    <= COEFF_W'(1);
            r_coeff_b    <= '0;
            r_prime      <= MOD_W'(101);
            r_bucket_cnt <= MCNT_W'(13);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEFF_A: r_coeff_a    <= i_cfg_data[COEFF_W-1:0];
                CFG_COEFF_B: r_coeff_b    <= i_cfg_data[COEFF_W-1:0];
                CFG_PRIME:   r_prime      <= i_cfg_data[MOD_W-1:0];
                CFG_BUCKETS: r_bucket_cnt <= i_cfg_data[MCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // bucket count zero means one bucket, anything above the table size saturates
    logic [MOD_W-1:0] m_eff;
    always_comb begin
        if (r_bucket_cnt == '0)
            m_eff = MOD_W'(1);
        else if (r_bucket_cnt > MCNT_W'(BUCKETS))
            m_eff = MOD_W'(BUCKETS);
        else
            m_eff = MOD_W'(r_bucket_cnt);
    end

    // ---------------- sequencer state ----------------
    t_state               r_state;
    logic [KEY_BITS-1:0]  r_key;
    logic [VAL_W-1:0]     r_val;
    logic [BKT_W-1:0]     r_bkt;
    logic [LEN_W-1:0]     r_len;
    logic [LEN_W-1:0]     r_idx;
    logic                 r_found;
    t_rem_req             r_rem_req;

    logic [TOTAL_W-1:0]    r_total;
    logic [LEN_W-1:0]      r_max;
    logic [NONEMPTY_W-1:0] r_used;

    logic                 rem_done;
    logic [MOD_W-1:0]     rem_val;

    // full-width a*k, 17 by 16 bits
    logic [COEFF_W+KEY_BITS-1:0] mul_prod;

    uhct_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_rem_req),
        .o_done  (rem_done),
        .o_rem   (rem_val)
    );

    // ---------------- stores ----------------
    // length store: memory plus one valid bit per bucket, an invalid bucket reads as empty
    logic [LEN_W-1:0]     mem_len [BUCKETS];
    logic [LEN_W-1:0]     r_len_q;
    logic [BUCKETS-1:0]   r_len_vld;
    // key store: undefined until written, only entries below a chain length are compared
    logic [KEY_BITS-1:0]  mem_keys [SLOTS];
    logic [KEY_BITS-1:0]  r_key_q;

    logic [SLOT_W-1:0]    slot_addr;
    logic [LEN_W-1:0]     len_now;
    logic                 ins;
    logic [LEN_W-1:0]     n_len;
    logic [ST_W-1:0]      n_status;
    logic [TOTAL_W-1:0]    n_total;
    logic [LEN_W-1:0]      n_max;
    logic [NONEMPTY_W-1:0] n_used;

    always_comb begin
        mul_prod = r_coeff_a * r_key;

        // DECIDE writes at the chain tail, scanning reads at the scan index
        slot_addr = SLOT_W'(r_bkt) * SLOT_W'(CHAIN_DEPTH)
                  + SLOT_W'((r_state == S_DECIDE) ? r_len : r_idx);
        len_now   = r_len_vld[r_bkt] ? r_len_q : '0;

        ins   = (r_state == S_DECIDE) && !r_found && (r_len < LEN_W'(CHAIN_DEPTH));
        n_len = r_len + 1'b1;

        if (r_found)
            n_status = ST_DUPLICATE;
        else if (r_len >= LEN_W'(CHAIN_DEPTH))
            n_status = ST_FULL;
        else
            n_status = ST_INSERTED;

        n_total = ins ? r_total + 1'b1 : r_total;
        n_used  = (ins && r_len == '0) ? r_used + 1'b1 : r_used;
        n_max   = (ins && n_len > r_max) ? n_len : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (ins) begin
            mem_keys[slot_addr] <= r_key;
            mem_len[r_bkt]      <= n_len;
        end
        r_key_q <= mem_keys[slot_addr];
        r_len_q <= mem_len[r_bkt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_len_vld <= '0;
        else if (ins)
            r_len_vld[r_bkt] <= 1'b1;
    end

    // ---------------- sequencer and registered results ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_found          <= 1'b0;
            r_rem_req        <= '0;
            r_total          <= '0;
            r_max            <= '0;
            r_used           <= '0;
            o_result_valid   <= 1'b0;
            o_bucket         <= '0;
            o_status         <= ST_INSERTED;
            o_stored_total   <= '0;
            o_longest_chain  <= '0;
            o_nonempty_total <= '0;
        end else begin
            o_result_valid  <= 1'b0;
            r_rem_req.start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_key   <= KEY_BITS'(i_key);
                        r_found <= 1'b0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_val   <= VAL_W'(mul_prod) + VAL_W'(r_coeff_b);
                    r_state <= S_RED1;
                end
                S_RED1: begin
                    // zero prime: skip the first reduction
                    if (r_prime != '0) begin
                        r_rem_req <= '{start: 1'b1, dividend: r_val, divisor: r_prime};
                        r_state   <= S_WAIT1;
                    end else begin
                        r_state   <= S_RED2;
                    end
                end
                S_WAIT1: begin
                    if (rem_done) begin
                        r_val   <= VAL_W'(rem_val);
                        r_state <= S_RED2;
                    end
                end
                S_RED2: begin
                    r_rem_req <= '{start: 1'b1, dividend: r_val, divisor: m_eff};
                    r_state   <= S_WAIT2;
                end
                S_WAIT2: begin
                    if (rem_done) begin
                        r_bkt   <= rem_val[BKT_W-1:0];
                        r_state <= S_LEN_RD;
                    end
                end
                S_LEN_RD: begin
                    r_state <= S_LEN_CHK;
                end
                S_LEN_CHK: begin
                    r_len   <= len_now;
                    r_idx   <= '0;
                    r_state <= (len_now == '0) ? S_DECIDE : S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CMP;
                end
                S_SCAN_CMP: begin
                    if (r_key_q == r_key) begin
                        r_found <= 1'b1;
                        r_state <= S_DECIDE;
                    end else if (LEN_W'(r_idx + 1'b1) == r_len) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_DECIDE: begin
                    r_total          <= n_total;
                    r_used           <= n_used;
                    r_max            <= n_max;
                    o_result_valid   <= 1'b1;
                    o_bucket         <= BUCKET_W'(r_bkt);
                    o_status         <= n_status;
                    o_stored_total   <= n_total;
                    o_longest_chain  <= LONGEST_W'(n_max);
                    o_nonempty_total <= n_used;
                    r_state          <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (r_state != S_IDLE);

    // ---------------- assertions ----------------
    // a result strobe lasts one cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // the block only leaves busy by delivering a result
    a_busy_ends_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_result_valid)
        else $error("busy dropped without a result");

    // duplicate or dropped keys leave the key count alone
    a_total_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != ST_INSERTED) |-> $stable(o_stored_total))
        else $error("key count changed on a rejected item");

    // the remainder unit is never launched while a result is being shown
    a_no_launch_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem_req.start |-> (busy && !o_result_valid))
        else $error("remainder unit launched outside an item");

endmodule
